### design/nlm_pkg.sv
// Node liveness monitor: shared types, codes and sizes.
// No dependencies; used by the top level and the testbench.
package nlm_pkg;

  localparam int TBL_DEPTH = 16;
  localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
  localparam int CFG_AW    = 5;

  localparam logic [1:0] REQ_HB   = 2'd0;
  localparam logic [1:0] REQ_LIST = 2'd1;
  localparam logic [1:0] REQ_NET  = 2'd2;
  localparam logic [1:0] REQ_SEND = 2'd3;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_CONN  = 2'd2;
  localparam logic [1:0] KIND_SEND  = 2'd3;

  localparam logic [1:0] LINK_WIFI = 2'd0;
  localparam logic [1:0] LINK_MESH = 2'd1;
  localparam logic [1:0] LINK_DISC = 2'd2;

  localparam logic [7:0] STATUS_OK   = 8'd0;
  localparam logic [7:0] STATUS_LOST = 8'd1;

  localparam logic [2:0] REG_OWN_ID  = 3'd0;
  localparam logic [2:0] REG_MESH_TO = 3'd1;
  localparam logic [2:0] REG_WIFI_TO = 3'd2;
  localparam logic [2:0] REG_SEND_TO = 3'd3;
  localparam logic [2:0] REG_RECV_TO = 3'd4;

  typedef struct packed {
    logic [15:0] node_id;
    logic [7:0]  status;
    logic        via_mesh;
    logic [31:0] stamp;
  } tbl_entry_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] entry_node_id;
    logic [7:0]  entry_status;
    logic        entry_via_mesh;
    logic [31:0] entry_stamp_ms;
    logic [1:0]  link_state;
    logic        last_result;
  } result_t;

endpackage

### design/nlm_in_if.sv
// Input item channel of the node liveness monitor.
// Depends on nothing but plain logic types.
interface nlm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic [15:0] node_id;
  logic        via_mesh;
  logic [7:0]  reported_status;

  modport source(output valid, req_type, now_ms, node_id, via_mesh, reported_status,
                 input ready);
  modport sink(input valid, req_type, now_ms, node_id, via_mesh, reported_status,
               output ready);
endinterface

### design/nlm_out_if.sv
// Result item channel of the node liveness monitor.
// Depends on nothing but plain logic types.
interface nlm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] entry_node_id;
  logic [7:0]  entry_status;
  logic        entry_via_mesh;
  logic [31:0] entry_stamp_ms;
  logic [1:0]  link_state;
  logic        last_result;

  modport source(output valid, result_kind, entry_node_id, entry_status, entry_via_mesh,
                 entry_stamp_ms, link_state, last_result, input ready);
  modport sink(input valid, result_kind, entry_node_id, entry_status, entry_via_mesh,
               entry_stamp_ms, link_state, last_result, output ready);
endinterface

### design/node_liveness_monitor.sv
// Node liveness monitor top level: ordered node table in one RAM, link state, APB regs.
// Depends on nlm_pkg, nlm_in_if and nlm_out_if.
//
//   channel  | dir | handshake               | carries
//   in_ch    | in  | valid/ready             | request type, time, heartbeat fields
//   out_ch   | out | valid/ready             | table entry / marker / link / send item
//   apb      | in  | psel/penable, pready=1  | five config registers at 4*i
//
// Heartbeat: a compaction scan through the table RAM, then the append; a second
//   scan pass comes first when the table is full and the front entry is evicted.
// List tick: per entry, a RAM read, then age check, write back and emit (emit waits for a free output).
// Reset is synchronous; table RAM is not cleared.
// A stalled output holds the result register; input is taken in idle when it can drain.
module node_liveness_monitor import nlm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  nlm_in_if.sink            in_ch,
  nlm_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_APPEND  = 5'b00100,
    ST_LT_RD   = 5'b01000,
    ST_LT_DATA = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TBL_DEPTH);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic             pend_r, pend_nxt;
  logic             shift_r, shift_nxt;
  tbl_entry_t       hb_r, hb_nxt;
  logic [31:0]      lt_now_r, lt_now_nxt;
  logic [31:0]      last_rx_r, last_rx_nxt;
  logic             rx_seen_r, rx_seen_nxt;
  logic [31:0]      last_tx_r, last_tx_nxt;
  logic             tx_seen_r, tx_seen_nxt;
  logic [1:0]       link_r, link_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;

  logic [15:0] own_id_r;
  logic [31:0] mesh_to_r, wifi_to_r, send_to_r, recv_to_r;

  tbl_entry_t mem [TBL_DEPTH];
  tbl_entry_t rdata_r;
  logic       we, re;
  logic [IDX_W-1:0] waddr, raddr;
  tbl_entry_t wdata;

  logic             out_free, in_acc;
  logic [CNT_W-1:0] limit, rd_inc;
  logic [31:0]      age, lim;
  tbl_entry_t       upd;
  logic [1:0]       link_n;
  logic             cfg_wr;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign limit       = shift_r ? DEPTH_C : cnt_r;
  assign rd_inc      = CNT_W'(rd_r + 1'b1);

  // age check of the entry just read for a list tick
  always_comb begin
    age = lt_now_r - rdata_r.stamp;
    lim = rdata_r.via_mesh ? mesh_to_r : wifi_to_r;
    upd = rdata_r;
    if (rdata_r.status != STATUS_LOST && age > lim) begin
      upd.status = STATUS_LOST;
    end
  end

  always_comb begin
    if (in_ch.now_ms - last_tx_r >= send_to_r) begin
      link_n = LINK_DISC;
    end else if (in_ch.now_ms - last_rx_r >= recv_to_r) begin
      link_n = LINK_MESH;
    end else begin
      link_n = LINK_WIFI;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    w_nxt         = w_r;
    pend_nxt      = pend_r;
    shift_nxt     = shift_r;
    hb_nxt        = hb_r;
    lt_now_nxt    = lt_now_r;
    last_rx_nxt   = last_rx_r;
    rx_seen_nxt   = rx_seen_r;
    last_tx_nxt   = last_tx_r;
    tx_seen_nxt   = tx_seen_r;
    link_nxt      = link_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = w_r[IDX_W-1:0];
    raddr         = rd_r[IDX_W-1:0];
    wdata         = rdata_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.req_type)
            REQ_HB: begin
              hb_nxt    = '{node_id: in_ch.node_id, status: in_ch.reported_status,
                            via_mesh: in_ch.via_mesh, stamp: in_ch.now_ms};
              rd_nxt    = '0;
              w_nxt     = '0;
              pend_nxt  = 1'b0;
              shift_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            REQ_LIST: begin
              lt_now_nxt = in_ch.now_ms;
              rd_nxt     = '0;
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{result_kind: KIND_EMPTY, entry_node_id: '0, entry_status: '0,
                            entry_via_mesh: 1'b0, entry_stamp_ms: '0,
                            link_state: link_r, last_result: 1'b1};
              end else begin
                state_nxt = ST_LT_RD;
              end
            end
            REQ_NET: begin
              if (rx_seen_r && tx_seen_r) begin
                link_nxt      = link_n;
                out_valid_nxt = 1'b1;
                out_nxt = '{result_kind: KIND_CONN, entry_node_id: '0, entry_status: '0,
                            entry_via_mesh: 1'b0, entry_stamp_ms: '0,
                            link_state: link_n, last_result: 1'b1};
              end
            end
            REQ_SEND: begin
              if (link_r == LINK_WIFI) begin
                last_tx_nxt   = in_ch.now_ms;
                tx_seen_nxt   = 1'b1;
                out_valid_nxt = 1'b1;
                out_nxt = '{result_kind: KIND_SEND, entry_node_id: own_id_r,
                            entry_status: STATUS_OK, entry_via_mesh: 1'b0,
                            entry_stamp_ms: in_ch.now_ms, link_state: link_r,
                            last_result: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // read runs one entry ahead of the compacting write, so w never passes rd
        if (rd_r < limit) begin
          re       = 1'b1;
          rd_nxt   = rd_inc;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (shift_r || rdata_r.node_id != hb_r.node_id)) begin
          we    = 1'b1;
          w_nxt = CNT_W'(w_r + 1'b1);
        end
        if (rd_r == limit && !pend_r) begin
          if (!shift_r && w_r == DEPTH_C) begin
            // full: second pass drops the front entry
            shift_nxt = 1'b1;
            rd_nxt    = CNT_W'(1);
            w_nxt     = '0;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        we        = 1'b1;
        wdata     = hb_r;
        cnt_nxt   = CNT_W'(w_r + 1'b1);
        state_nxt = ST_IDLE;
        if (hb_r.node_id != own_id_r) begin
          last_rx_nxt = hb_r.stamp;
          rx_seen_nxt = 1'b1;
        end
      end
      ST_LT_RD: begin
        re        = 1'b1;
        state_nxt = ST_LT_DATA;
      end
      ST_LT_DATA: begin
        if (out_free) begin
          we            = 1'b1;
          waddr         = rd_r[IDX_W-1:0];
          wdata         = upd;
          out_valid_nxt = 1'b1;
          out_nxt = '{result_kind: KIND_ENTRY, entry_node_id: upd.node_id,
                      entry_status: upd.status, entry_via_mesh: upd.via_mesh,
                      entry_stamp_ms: upd.stamp, link_state: link_r,
                      last_result: rd_inc == cnt_r};
          rd_nxt    = rd_inc;
          state_nxt = (rd_inc == cnt_r) ? ST_IDLE : ST_LT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      shift_r     <= 1'b0;
      last_rx_r   <= '0;
      rx_seen_r   <= 1'b0;
      last_tx_r   <= '0;
      tx_seen_r   <= 1'b0;
      link_r      <= LINK_WIFI;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      shift_r     <= shift_nxt;
      last_rx_r   <= last_rx_nxt;
      rx_seen_r   <= rx_seen_nxt;
      last_tx_r   <= last_tx_nxt;
      tx_seen_r   <= tx_seen_nxt;
      link_r      <= link_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r     <= rd_nxt;
    w_r      <= w_nxt;
    hb_r     <= hb_nxt;
    lt_now_r <= lt_now_nxt;
    out_r    <= out_nxt;
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r  <= 16'd1;
      mesh_to_r <= 32'd5000;
      wifi_to_r <= 32'd2000;
      send_to_r <= 32'd30000;
      recv_to_r <= 32'd5000;
    end else if (cfg_wr) begin
      unique case (paddr[CFG_AW-1:2])
        REG_OWN_ID:  own_id_r  <= pwdata[15:0];
        REG_MESH_TO: mesh_to_r <= pwdata;
        REG_WIFI_TO: wifi_to_r <= pwdata;
        REG_SEND_TO: send_to_r <= pwdata;
        REG_RECV_TO: recv_to_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_AW-1:2])
      REG_OWN_ID:  prdata = {16'd0, own_id_r};
      REG_MESH_TO: prdata = mesh_to_r;
      REG_WIFI_TO: prdata = wifi_to_r;
      REG_SEND_TO: prdata = send_to_r;
      REG_RECV_TO: prdata = recv_to_r;
      default:     prdata = '0;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_r.result_kind;
  assign out_ch.entry_node_id  = out_r.entry_node_id;
  assign out_ch.entry_status   = out_r.entry_status;
  assign out_ch.entry_via_mesh = out_r.entry_via_mesh;
  assign out_ch.entry_stamp_ms = out_r.entry_stamp_ms;
  assign out_ch.link_state     = out_r.link_state;
  assign out_ch.last_result    = out_r.last_result;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("table count above depth");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !shift_r) |-> w_r <= rd_r)
    else $error("compaction write passed read pointer");

  a_lt_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LT_DATA) |-> ($past(state_r) == ST_LT_RD || $past(state_r) == ST_LT_DATA))
    else $error("list data state without a read");

  a_lt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LT_RD) |-> rd_r < cnt_r)
    else $error("list read beyond table count");

endmodule

### tb/sv/node_liveness_monitor_tb.sv
// Testbench for node_liveness_monitor: directed and random heartbeats and ticks,
// with results checked against a local model. Uses nlm_pkg, nlm_in_if, nlm_out_if.
module node_liveness_monitor_tb;
  import nlm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nlm_in_if in_if ();
  nlm_out_if out_if ();

  node_liveness_monitor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the monitor's registers and state
  logic [15:0] own_id;
  logic [31:0] mesh_to, wifi_to, send_to, recv_to;
  tbl_entry_t  node_tbl [TBL_DEPTH];
  int          node_cnt;
  logic [31:0] last_rx_ms, last_tx_ms;
  logic        rx_seen, tx_seen;
  logic [1:0]  link_now;

  result_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [31:0] clock_ms = 32'd0;
  longint cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_HB;
    in_if.now_ms = '0;
    in_if.node_id = '0;
    in_if.via_mesh = 1'b0;
    in_if.reported_status = '0;
    out_if.ready = 1'b0;
  end

  function automatic void push_result(logic [1:0] kind, logic [15:0] id, logic [7:0] st,
                                      logic mesh, logic [31:0] stamp, logic last);
    result_t r;
    r.result_kind = kind;
    r.entry_node_id = id;
    r.entry_status = st;
    r.entry_via_mesh = mesh;
    r.entry_stamp_ms = stamp;
    r.link_state = link_now;
    r.last_result = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_monitor(logic [1:0] req, logic [31:0] now, logic [15:0] id,
                                          logic mesh, logic [7:0] st);
    int w;
    logic [31:0] age, lim;
    case (req)
      REQ_HB: begin
        w = 0;
        for (int r = 0; r < node_cnt; r++) begin
          if (node_tbl[r].node_id != id) begin
            node_tbl[w] = node_tbl[r];
            w++;
          end
        end
        node_cnt = w;
        if (node_cnt >= TBL_DEPTH) begin
          for (int r = 1; r < TBL_DEPTH; r++) node_tbl[r-1] = node_tbl[r];
          node_cnt = TBL_DEPTH - 1;
        end
        node_tbl[node_cnt] = '{node_id: id, status: st, via_mesh: mesh, stamp: now};
        node_cnt++;
        if (id != own_id) begin
          last_rx_ms = now;
          rx_seen = 1'b1;
        end
      end
      REQ_LIST: begin
        if (node_cnt == 0) begin
          push_result(KIND_EMPTY, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < node_cnt; i++) begin
            if (node_tbl[i].status != STATUS_LOST) begin
              age = now - node_tbl[i].stamp;
              lim = node_tbl[i].via_mesh ? mesh_to : wifi_to;
              if (age > lim) node_tbl[i].status = STATUS_LOST;
            end
            push_result(KIND_ENTRY, node_tbl[i].node_id, node_tbl[i].status,
                        node_tbl[i].via_mesh, node_tbl[i].stamp, i == node_cnt - 1);
          end
        end
      end
      REQ_NET: begin
        if (rx_seen && tx_seen) begin
          if (now - last_tx_ms >= send_to) link_now = LINK_DISC;
          else if (now - last_rx_ms >= recv_to) link_now = LINK_MESH;
          else link_now = LINK_WIFI;
          push_result(KIND_CONN, '0, '0, 1'b0, '0, 1'b1);
        end
      end
      default: begin
        if (link_now == LINK_WIFI) begin
          last_tx_ms = now;
          tx_seen = 1'b1;
          push_result(KIND_SEND, own_id, STATUS_OK, 1'b0, now, 1'b1);
        end
      end
    endcase
  endfunction

  // sender: valid stays high across back-to-back items
  task automatic send_item(logic [1:0] req, logic [31:0] now, logic [15:0] id,
                           logic mesh, logic [7:0] st);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    predict_monitor(req, now, id, mesh, st);
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.now_ms <= now;
    in_if.node_id <= id;
    in_if.via_mesh <= mesh;
    in_if.reported_status <= st;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OWN_ID:  own_id = val[15:0];
      REG_MESH_TO: mesh_to = val;
      REG_WIFI_TO: wifi_to = val;
      REG_SEND_TO: send_to = val;
      default:     recv_to = val;
    endcase
  endtask

  task automatic configure(logic [15:0] id, logic [31:0] m, logic [31:0] w,
                           logic [31:0] s, logic [31:0] r);
    wait_idle();
    cfg_write(REG_OWN_ID, {16'd0, id});
    cfg_write(REG_MESH_TO, m);
    cfg_write(REG_WIFI_TO, w);
    cfg_write(REG_SEND_TO, s);
    cfg_write(REG_RECV_TO, r);
  endtask

  task automatic test_basics();
    clock_ms = 32'd1000;
    send_item(REQ_LIST, clock_ms, 16'd0, 1'b0, 8'd0);      // empty table marker
    send_item(REQ_NET, clock_ms, 16'd0, 1'b0, 8'd0);       // nothing seen: silent
    send_item(REQ_SEND, clock_ms, 16'hFFFF, 1'b1, 8'hFF);
    send_item(REQ_NET, clock_ms + 10, 16'd0, 1'b0, 8'd0);  // sent but not received
    send_item(REQ_HB, clock_ms + 20, own_id, 1'b0, 8'd0);  // own beat is not a receive
    send_item(REQ_NET, clock_ms + 30, 16'd0, 1'b0, 8'd0);
    send_item(REQ_HB, clock_ms + 40, 16'hFFFF, 1'b1, 8'hFF);
    send_item(REQ_HB, clock_ms + 50, 16'd7, 1'b0, 8'd0);
    send_item(REQ_HB, clock_ms + 60, 16'hFFFF, 1'b0, 8'd1); // refresh moves it to the back
    send_item(REQ_LIST, clock_ms + 2060, 16'd0, 1'b0, 8'd0); // wifi age exactly at limit
    send_item(REQ_LIST, clock_ms + 2061, 16'd0, 1'b0, 8'd0);
    send_item(REQ_NET, clock_ms + 100, 16'd0, 1'b0, 8'd0);
    send_item(REQ_NET, clock_ms + 60 + recv_to, 16'd0, 1'b0, 8'd0); // -> mesh
    send_item(REQ_SEND, clock_ms + 6000, 16'd0, 1'b0, 8'd0);       // not in wifi
    send_item(REQ_NET, clock_ms + send_to, 16'd0, 1'b0, 8'd0);      // -> disconnected
    send_item(REQ_LIST, 32'hFFFF_FFFF, 16'd0, 1'b0, 8'd0);
  endtask

  task automatic test_eviction();
    clock_ms = 32'hFFFF_FF00; // time wraps during the fill
    for (int i = 0; i < TBL_DEPTH + 2; i++) begin
      clock_ms += 32'd37;
      send_item(REQ_HB, clock_ms, 16'(100 + i), i[0], 8'(i));
    end
    send_item(REQ_LIST, clock_ms + 1, 16'd0, 1'b0, 8'd0);
    send_item(REQ_HB, clock_ms + 2, 16'd105, 1'b1, 8'd0); // refresh of a middle entry
    send_item(REQ_LIST, clock_ms + 3, 16'd0, 1'b0, 8'd0);
  endtask

  task automatic test_config_extremes();
    configure(16'hFFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    clock_ms = 32'd50;
    send_item(REQ_HB, clock_ms, 16'd3, 1'b1, 8'd0);
    send_item(REQ_HB, clock_ms, 16'hFFFF, 1'b0, 8'd0);
    send_item(REQ_LIST, clock_ms, 16'd0, 1'b0, 8'd0);      // age 0: still ok
    send_item(REQ_LIST, clock_ms + 1, 16'd0, 1'b0, 8'd0);  // age 1 > 0: lost
    send_item(REQ_NET, clock_ms + 2, 16'd0, 1'b0, 8'd0);
    configure(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_item(REQ_HB, clock_ms + 3, 16'd9, 1'b0, 8'd0);
    send_item(REQ_LIST, clock_ms - 4, 16'd0, 1'b0, 8'd0);
    send_item(REQ_NET, clock_ms + 4, 16'd0, 1'b0, 8'd0);   // zero send timeout
    send_item(REQ_SEND, clock_ms + 5, 16'd0, 1'b0, 8'd0);
  endtask

  task automatic test_random(int n, int snd, int rcv);
    logic [1:0] req;
    logic [15:0] id;
    logic [7:0] st;
    int pick;
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    configure(16'($urandom_range(0, 3)), $urandom_range(500, 6000), $urandom_range(200, 4000),
              $urandom_range(8000, 60000), $urandom_range(1000, 8000));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      req = pick < 45 ? REQ_HB : pick < 65 ? REQ_LIST : pick < 85 ? REQ_NET : REQ_SEND;
      clock_ms += $urandom_range(0, 2500);
      if ($urandom_range(99) < 3) clock_ms = $urandom;
      id = $urandom_range(99) < 80 ? 16'($urandom_range(0, 20)) : 16'($urandom_range(0, 65535));
      st = $urandom_range(99) < 70 ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
      send_item(req, clock_ms, id, 1'($urandom_range(0, 1)), st);
      if (i == n / 2) wait_idle(); // hold off until the block has drained
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item, kind %0d", out_if.result_kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("result_kind", 32'(e.result_kind), 32'(out_if.result_kind));
        check_field("entry_node_id", 32'(e.entry_node_id), 32'(out_if.entry_node_id));
        check_field("entry_status", 32'(e.entry_status), 32'(out_if.entry_status));
        check_field("entry_via_mesh", 32'(e.entry_via_mesh), 32'(out_if.entry_via_mesh));
        check_field("entry_stamp_ms", e.entry_stamp_ms, out_if.entry_stamp_ms);
        check_field("link_state", 32'(e.link_state), 32'(out_if.link_state));
        check_field("last_result", 32'(e.last_result), 32'(out_if.last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    own_id = 16'd1;
    mesh_to = 32'd5000;
    wifi_to = 32'd2000;
    send_to = 32'd30000;
    recv_to = 32'd5000;
    node_cnt = 0;
    last_rx_ms = '0;
    last_tx_ms = '0;
    rx_seen = 1'b0;
    tx_seen = 1'b0;
    link_now = LINK_WIFI;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 47;
    test_basics();
    test_eviction();
    test_config_extremes();
    test_random(45, 15, 47);
    test_random(45, 47, 15);
    test_random(45, 0, 0);
    wait_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
